### sv/point_cloud_transform_filter_assert.svh
// Assertion macros for the point cloud transform filter.
`ifndef POINT_CLOUD_TRANSFORM_FILTER_ASSERT_SVH
`define POINT_CLOUD_TRANSFORM_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define PCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("point cloud filter check failed");
`define PCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("point cloud filter check failed");
`else
`define PCT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/pct_pkg.sv
// Shared types and constants of the point cloud transform filter.
package pct_pkg;

  localparam int CRD_W     = 18;
  localparam int COEF_W    = 16;
  localparam int FRAC_W    = 14;
  localparam int PROD_W    = COEF_W + CRD_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int ROW_W     = 3 * COEF_W;
  localparam int CNT_W     = 17;
  localparam int CNT_MAX   = 131071;
  localparam int CFG_IDX_W = 3;
  localparam int TDATA_W   = 56;

  localparam int DEFAULT_MAX_POINTS = 65536;

  typedef logic signed [CRD_W-1:0]  crd_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [ROW_W-1:0]         row_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  localparam crd_t EXCL_POS = crd_t'(300);
  localparam crd_t EXCL_NEG = crd_t'(-300);

  localparam row_t ROT_X_RST = 48'h4000_0000_0000;
  localparam row_t ROT_Y_RST = 48'h0000_4000_0000;
  localparam row_t ROT_Z_RST = 48'h0000_0000_4000;
  localparam crd_t FLOOR_RST = crd_t'(50);
  localparam crd_t CEIL_RST  = crd_t'(500);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_X = 3'd0,
    CFG_ROT_Y = 3'd1,
    CFG_ROT_Z = 3'd2,
    CFG_SHF_X = 3'd3,
    CFG_SHF_Y = 3'd4,
    CFG_SHF_Z = 3'd5,
    CFG_FLOOR = 3'd6,
    CFG_CEIL  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic last;
  } stage_ctl_t;

endpackage

### sv/pct_mult_stage.sv
// Product stage: nine coefficient by coordinate products, registered.
module pct_mult_stage
  import pct_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  crd_t  pt_x,
  input  crd_t  pt_y,
  input  crd_t  pt_z,
  input  row_t  row_x,
  input  row_t  row_y,
  input  row_t  row_z,
  output prod_t prod_r [3][3]
);

  crd_t  pt  [3];
  row_t  row [3];
  prod_t prod_nxt [3][3];

  assign pt[0]  = pt_x;
  assign pt[1]  = pt_y;
  assign pt[2]  = pt_z;
  assign row[0] = row_x;
  assign row[1] = row_y;
  assign row[2] = row_z;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      coef_t coef;
      assign coef = $signed(row[r][ROW_W-1-COEF_W*c -: COEF_W]);
      assign prod_nxt[r][c] = PROD_W'(coef) * PROD_W'(pt[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

### sv/pct_row_sum.sv
// Row sum: adds three products and the translation, floors and saturates.
module pct_row_sum
  import pct_pkg::*;
(
  input  prod_t p0,
  input  prod_t p1,
  input  prod_t p2,
  input  crd_t  shift,
  output crd_t  coord
);

  localparam int Q_W = ACC_W - FRAC_W;

  logic signed [ACC_W-1:0] acc;
  logic signed [Q_W-1:0]   q;

  always_comb begin
    acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2)
        + {{(ACC_W-CRD_W-FRAC_W){shift[CRD_W-1]}}, shift, {FRAC_W{1'b0}}};
    // Dropping the fraction bits of a two's complement sum rounds downwards.
    q = acc[ACC_W-1:FRAC_W];
    if (q[Q_W-1:CRD_W-1] == {(Q_W-CRD_W+1){1'b0}} ||
        q[Q_W-1:CRD_W-1] == {(Q_W-CRD_W+1){1'b1}}) begin
      coord = q[CRD_W-1:0];
    end else if (q[Q_W-1]) begin
      coord = {1'b1, {(CRD_W-1){1'b0}}};
    end else begin
      coord = {1'b0, {(CRD_W-1){1'b1}}};
    end
  end

endmodule

### sv/pct_filter_stage.sv
// Filter stage: height band and axis exclusion test, kept count, result register.
module pct_filter_stage
  import pct_pkg::*;
#(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t ctl,
  input  crd_t       base_x,
  input  crd_t       base_y,
  input  crd_t       base_z,
  input  crd_t       floor_h,
  input  crd_t       ceil_h,
  output logic       keep_r,
  output crd_t       base_x_r,
  output crd_t       base_y_r,
  output cnt_t       total_r,
  output logic       last_r
);

  localparam int   LIMIT   = (MAX_POINTS < CNT_MAX) ? MAX_POINTS : CNT_MAX;
  localparam cnt_t LIMIT_V = CNT_W'(LIMIT);

  cnt_t cnt_r;
  cnt_t cnt_nxt;
  cnt_t total_nxt;
  logic keep_nxt;

  always_comb begin
    keep_nxt = (base_z >= floor_h) && (base_z <= ceil_h)
            && ((base_x >= EXCL_POS) || (base_x <= EXCL_NEG))
            && ((base_y >= EXCL_POS) || (base_y <= EXCL_NEG));
    total_nxt = (keep_nxt && cnt_r < LIMIT_V) ? cnt_r + 1'b1 : cnt_r;
    cnt_nxt   = ctl.last ? '0 : total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.load) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      keep_r   <= keep_nxt;
      base_x_r <= base_x;
      base_y_r <= base_y;
      total_r  <= total_nxt;
      last_r   <= ctl.last;
    end
  end

endmodule

### sv/point_cloud_transform_filter.sv
// Top level of the point cloud transform filter.
// Each request carries one point; the block rotates it by a Q1.14 matrix, adds the
// translation, floors and saturates to 18 bits, then keeps it when its height lies in
// the configured band and both x and y are at least 300 mm from zero. Every request
// gives one result with the keep flag, base x and y, and the count of kept points in
// the current cloud, which clears after the point marked last. One request is taken
// per clock unless out_tready back-pressure stalls the pipeline; a request passes the
// input, product and result registers in turn. Configuration is to be written only
// while no request is in flight; the block itself does not enforce this.
`include "point_cloud_transform_filter_assert.svh"

module point_cloud_transform_filter
  import pct_pkg::*;
#(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [TDATA_W-1:0]   in_tdata,   // point_x, point_y, point_z, zero fill
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TDATA_W-1:0]   out_tdata,  // base_x, base_y, kept_total, zero fill
  output logic                 out_tuser,  // keep
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_wdata
);

  localparam int   LIMIT   = (MAX_POINTS < CNT_MAX) ? MAX_POINTS : CNT_MAX;
  localparam cnt_t LIMIT_V = CNT_W'(LIMIT);

  row_t rot_x_r, rot_y_r, rot_z_r;
  crd_t shf_x_r, shf_y_r, shf_z_r, floor_r, ceil_r;

  logic s1_valid_r, s2_valid_r, out_valid_r;
  crd_t s1_x_r, s1_y_r, s1_z_r;
  logic s1_last_r, s2_last_r;
  logic s1_adv, s2_adv, out_adv;

  prod_t      prod_r [3][3];
  crd_t       sum_x, sum_y, sum_z;
  stage_ctl_t filt_ctl;

  logic keep_r, last_r;
  crd_t base_x_r, base_y_r;
  cnt_t total_r;

  assign out_adv   = !out_valid_r || out_tready;
  assign s2_adv    = !s2_valid_r || out_adv;
  assign s1_adv    = !s1_valid_r || s2_adv;
  assign in_tready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_x_r <= ROT_X_RST;
      rot_y_r <= ROT_Y_RST;
      rot_z_r <= ROT_Z_RST;
      shf_x_r <= '0;
      shf_y_r <= '0;
      shf_z_r <= '0;
      floor_r <= FLOOR_RST;
      ceil_r  <= CEIL_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROT_X: rot_x_r <= cfg_wdata;
        CFG_ROT_Y: rot_y_r <= cfg_wdata;
        CFG_ROT_Z: rot_z_r <= cfg_wdata;
        CFG_SHF_X: shf_x_r <= cfg_wdata[CRD_W-1:0];
        CFG_SHF_Y: shf_y_r <= cfg_wdata[CRD_W-1:0];
        CFG_SHF_Z: shf_z_r <= cfg_wdata[CRD_W-1:0];
        CFG_FLOOR: floor_r <= cfg_wdata[CRD_W-1:0];
        CFG_CEIL:  ceil_r  <= cfg_wdata[CRD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_adv) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_adv) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s1_adv) begin
      s1_x_r    <= in_tdata[CRD_W-1:0];
      s1_y_r    <= in_tdata[2*CRD_W-1:CRD_W];
      s1_z_r    <= in_tdata[3*CRD_W-1:2*CRD_W];
      s1_last_r <= in_tlast;
    end
    if (s1_valid_r && s2_adv) begin
      s2_last_r <= s1_last_r;
    end
  end

  pct_mult_stage u_mult (
    .clk    (clk),
    .en     (s1_valid_r && s2_adv),
    .pt_x   (s1_x_r),
    .pt_y   (s1_y_r),
    .pt_z   (s1_z_r),
    .row_x  (rot_x_r),
    .row_y  (rot_y_r),
    .row_z  (rot_z_r),
    .prod_r (prod_r)
  );

  pct_row_sum u_sum_x (
    .p0    (prod_r[0][0]),
    .p1    (prod_r[0][1]),
    .p2    (prod_r[0][2]),
    .shift (shf_x_r),
    .coord (sum_x)
  );

  pct_row_sum u_sum_y (
    .p0    (prod_r[1][0]),
    .p1    (prod_r[1][1]),
    .p2    (prod_r[1][2]),
    .shift (shf_y_r),
    .coord (sum_y)
  );

  pct_row_sum u_sum_z (
    .p0    (prod_r[2][0]),
    .p1    (prod_r[2][1]),
    .p2    (prod_r[2][2]),
    .shift (shf_z_r),
    .coord (sum_z)
  );

  assign filt_ctl.load = s2_valid_r && out_adv;
  assign filt_ctl.last = s2_last_r;

  pct_filter_stage #(
    .MAX_POINTS (MAX_POINTS)
  ) u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (filt_ctl),
    .base_x   (sum_x),
    .base_y   (sum_y),
    .base_z   (sum_z),
    .floor_h  (floor_r),
    .ceil_h   (ceil_r),
    .keep_r   (keep_r),
    .base_x_r (base_x_r),
    .base_y_r (base_y_r),
    .total_r  (total_r),
    .last_r   (last_r)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-2*CRD_W-CNT_W){1'b0}}, total_r, base_y_r, base_x_r};
  assign out_tuser  = keep_r;
  assign out_tlast  = last_r;

  `PCT_ASSERT_NOW(a_total_in_limit, clk, rst_n, out_valid_r, total_r <= LIMIT_V)
  `PCT_ASSERT_NOW(a_keep_counts, clk, rst_n, out_valid_r && keep_r, total_r != '0)
  `PCT_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_r && !s2_adv, s1_valid_r)

endmodule
